// File: hdl/pti_pkg.sv
// Shared types and constants for the pointer table integrity monitor.
`timescale 1ns / 1ps

package pti_pkg;

  localparam int MAX_ARRAYS  = 8;
  localparam int MAX_ENTRIES = 64;

  localparam int ARR_W     = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int ENT_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AC_W      = $clog2(MAX_ARRAYS + 1);
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W    = CNT_W + 16;
  localparam int MEM_AW    = ARR_W + ENT_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_SNAPSHOT = 2'd1;
  localparam logic [1:0] OP_CHECK    = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_REMOVED = 2'd1;
  localparam logic [1:0] KIND_OUTSIDE = 2'd2;
  localparam logic [1:0] KIND_CHANGED = 2'd3;

  localparam logic [15:0] PASS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  array_index;
    logic [5:0]  entry_index;
    logic [63:0] pointer_value;
    logic [63:0] address;
    logic [15:0] entry_total;
    logic [15:0] entry_bytes;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic        last_of_pass;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  anomaly_kind;
    logic        monitored;
    logic [15:0] pass_anomalies;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } pti_cmd_t;

  typedef struct packed {
    logic clear_done;
  } pti_sts_t;

endpackage

// File: hdl/pointer_table_integrity_monitor.sv
// Top level of the pointer table integrity monitor.
`timescale 1ns / 1ps

// After reset the block sweeps its 512-entry baseline memory to zero, one entry
// per cycle, and accepts no item until the sweep is done. From then on each item
// passes an accept cycle and an execute cycle: the accept cycle reads the
// baseline entry from the single-port memory, and the execute cycle that follows
// classifies the pointer, writes the baseline back and updates the array table.
// A finished result sits in an output register, so the next item is accepted while
// it waits; the execute cycle stalls only when an earlier result has still not been taken.
module pointer_table_integrity_monitor import pti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  pti_cmd_t cmd;
  pti_sts_t sts;

  pti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pti_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !in_ready_o)
    else $error("item accepted during baseline clearing");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ready_o)
    else $error("second item accepted before the first executed");

  a_exec_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_valid_o)
    else $error("executed item produced no result");

  a_exec_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

// File: hdl/pti_ctrl.sv
// Sequencer for the monitor: clearing sweep, item accept, execute and output valid.
`timescale 1ns / 1ps

module pti_ctrl import pti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pti_sts_t sts_i,
  output pti_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold while the previous result still waits
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/pti_dp.sv
// Datapath: array table, baseline memory, classification, pass counter, result register.
`timescale 1ns / 1ps

module pti_dp import pti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pti_cmd_t  cmd_i,
  output pti_sts_t  sts_o,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  logic [MEM_AW-1:0] clr_q, clr_d;
  in_item_t          item_q;
  logic [PROD_W-1:0] prod_q;
  logic [63:0]       rd_q;
  logic [63:0]       mem [MEM_DEPTH];

  logic [AC_W-1:0]       count_q, count_d;
  logic [MAX_ARRAYS-1:0] armed_q, armed_d;
  logic [15:0]           pass_q, pass_d;

  logic [63:0]      base_q [MAX_ARRAYS];
  logic [63:0]      end_q  [MAX_ARRAYS];
  logic [63:0]      low_q  [MAX_ARRAYS];
  logic [63:0]      high_q [MAX_ARRAYS];
  logic [CNT_W-1:0] ecnt_q [MAX_ARRAYS];

  logic [CNT_W-1:0]  clamp;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] slot;
  logic [ARR_W-1:0]  idx;
  logic [ARR_W-1:0]  reg_slot;
  logic              arr_ok;
  logic              ent_ok;
  logic              chk_ok;
  logic              tbl_we;
  logic [1:0]        kind;
  logic              hit;
  logic [15:0]       pass_inc;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [63:0]       mem_wdata;
  out_item_t         out_q, out_d;

  // clamp entry count and form the size product at accept
  always_comb begin
    if (in_item_i.entry_total > 16'(MAX_ENTRIES)) begin
      clamp = CNT_W'(MAX_ENTRIES);
    end else begin
      clamp = in_item_i.entry_total[CNT_W-1:0];
    end
  end

  assign rd_addr  = {in_item_i.array_index[ARR_W-1:0], in_item_i.entry_index[ENT_W-1:0]};
  assign slot     = {item_q.array_index[ARR_W-1:0], item_q.entry_index[ENT_W-1:0]};
  assign idx      = item_q.array_index[ARR_W-1:0];
  assign reg_slot = count_q[ARR_W-1:0];

  assign arr_ok = AC_W'(item_q.array_index) < count_q;
  assign ent_ok = arr_ok && (CNT_W'(item_q.entry_index) < ecnt_q[idx]);
  assign chk_ok = ent_ok && armed_q[idx];
  assign tbl_we = cmd_i.exec && (item_q.operation == OP_REGISTER)
                  && (count_q < AC_W'(MAX_ARRAYS));

  always_comb begin
    priority if (item_q.pointer_value == rd_q) begin
      kind = KIND_NONE;
    end else if (item_q.pointer_value == 64'd0) begin
      kind = KIND_REMOVED;
    end else if (item_q.pointer_value < low_q[idx] || item_q.pointer_value > high_q[idx]) begin
      kind = KIND_OUTSIDE;
    end else begin
      kind = KIND_CHANGED;
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < MAX_ARRAYS; i++) begin
      if (AC_W'(i) < count_q && item_q.address >= base_q[i] && item_q.address < end_q[i]) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (chk_ok && kind != KIND_NONE && pass_q != PASS_MAX) begin
      pass_inc = pass_q + 16'd1;
    end else begin
      pass_inc = pass_q;
    end
  end

  always_comb begin
    count_d = count_q;
    armed_d = armed_q;
    pass_d  = pass_q;
    out_d   = '0;
    unique case (item_q.operation)
      OP_REGISTER: begin
        if (count_q < AC_W'(MAX_ARRAYS)) begin
          out_d.accepted     = 1'b1;
          count_d            = count_q + AC_W'(1);
          armed_d[reg_slot]  = 1'b0;
        end
      end
      OP_SNAPSHOT: begin
        out_d.accepted = ent_ok;
        if (arr_ok && item_q.last_of_pass) begin
          armed_d[idx] = 1'b1;
        end
      end
      OP_CHECK: begin
        out_d.accepted       = chk_ok;
        out_d.anomaly_kind   = chk_ok ? kind : KIND_NONE;
        out_d.pass_anomalies = pass_inc;
        pass_d               = item_q.last_of_pass ? 16'd0 : pass_inc;
      end
      OP_QUERY: begin
        out_d.monitored = hit;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  assign mem_we = cmd_i.clear
                  || (cmd_i.exec && item_q.operation == OP_SNAPSHOT && ent_ok)
                  || (cmd_i.exec && item_q.operation == OP_CHECK && chk_ok
                      && kind != KIND_NONE);
  assign mem_addr  = cmd_i.clear ? clr_q : slot;
  assign mem_wdata = cmd_i.clear ? 64'd0 : item_q.pointer_value;

  assign clr_d = clr_q + MEM_AW'(1);
  assign sts_o.clear_done = (clr_q == MEM_AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (cmd_i.load) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
      prod_q <= PROD_W'(clamp) * PROD_W'(in_item_i.entry_bytes);
    end
    if (tbl_we) begin
      base_q[reg_slot] <= item_q.address;
      end_q[reg_slot]  <= item_q.address + 64'(prod_q);
      low_q[reg_slot]  <= item_q.range_low;
      high_q[reg_slot] <= item_q.range_high;
      ecnt_q[reg_slot] <= (item_q.entry_total > 16'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                          : item_q.entry_total[CNT_W-1:0];
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      count_q <= '0;
      armed_q <= '0;
      pass_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_d;
      end
      if (cmd_i.exec) begin
        count_q <= count_d;
        armed_q <= armed_d;
        pass_q  <= pass_d;
      end
    end
  end

  assign out_item_o = out_q;

endmodule
